// ===== sv/dq_pkg.sv =====
package dq_pkg;

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_CLEAR      = 3'd4,
        CMD_QUERY      = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_IN,
        CELL_SHIFT_OUT,
        CELL_WRITE
    } t_cell_op;

endpackage

// ===== sv/dq_if.sv =====
interface dq_cmd_if
    import dq_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink (input valid, input cmd, input push_value, output ready);
endinterface

interface dq_res_if
    import dq_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] popped_value;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] back_value;
    logic [OCC_W-1:0]          occupancy;
    logic                      is_empty;

    modport source (
        output valid, output status, output popped_value, output front_value,
        output back_value, output occupancy, output is_empty, input ready
    );
    modport sink (
        input valid, input status, input popped_value, input front_value,
        input back_value, input occupancy, input is_empty, output ready
    );
endinterface

// ===== sv/dq_cell.sv =====
module dq_cell
    import dq_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int CW         = 5,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  t_cell_op              i_op,
    input  logic [CW-1:0]         i_count,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_prev,
    input  logic [DATA_WIDTH-1:0] i_next,
    output logic [DATA_WIDTH-1:0] o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_op)
            CELL_SHIFT_IN:  n_data = i_prev;
            CELL_SHIFT_OUT: n_data = i_next;
            CELL_WRITE: begin
                if (i_count == CW'(INDEX)) begin
                    n_data = i_value;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== sv/dq_chain.sv =====
module dq_chain
    import dq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int CW         = 5
) (
    input  logic                  i_clk,
    input  t_cell_op              i_op,
    input  logic [CW-1:0]         i_count,
    input  logic [DATA_WIDTH-1:0] i_value,
    output logic [DATA_WIDTH-1:0] o_head
);

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] prev_data;
        logic [DATA_WIDTH-1:0] next_data;

        if (g == 0) begin : g_first
            assign prev_data = i_value;
        end else begin : g_inner
            assign prev_data = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign next_data = cell_data[g];
        end else begin : g_body
            assign next_data = cell_data[g+1];
        end

        dq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CW         (CW),
            .INDEX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (i_op),
            .i_count (i_count),
            .i_value (i_value),
            .i_prev  (prev_data),
            .i_next  (next_data),
            .o_data  (cell_data[g])
        );
    end

    assign o_head = cell_data[0];

endmodule

// ===== sv/double_ended_queue.sv =====
// Bounded double-ended queue of DEPTH signed entries, kept in two rows of
// cells that hold the same entries in opposite order: one row has the front
// in its first cell and the other has the back there. A push shifts one row
// and writes the other, a pop shifts one row; a command is taken every clock
// cycle and its result appears in the cycle after it is accepted; a stalled
// result holds the next request back. Pops of an empty queue report underflow
// and pushes into a full queue report overflow; neither changes the contents.
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dq_cmd_if.sink   i_cmd,
    dq_res_if.source o_res
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int EXT_W = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_out_valid;
    t_status               r_status;
    t_status               n_status;
    logic [VALUE_W-1:0]    r_popped;
    logic [VALUE_W-1:0]    n_popped;

    logic                  accept;
    logic                  full;
    logic                  empty;
    t_cmd                  cmd_in;
    t_cell_op              op_front;
    t_cell_op              op_back;
    logic [EXT_W-1:0]      value_ext;
    logic [DATA_WIDTH-1:0] value;
    logic [DATA_WIDTH-1:0] front_head;
    logic [DATA_WIDTH-1:0] back_head;
    logic [EXT_W-1:0]      front_ext;
    logic [EXT_W-1:0]      back_ext;

    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign full        = (r_count == CW'(DEPTH));
    assign empty       = (r_count == '0);
    assign cmd_in      = t_cmd'(i_cmd.cmd);
    assign value_ext   = EXT_W'(i_cmd.push_value);
    assign value       = value_ext[DATA_WIDTH-1:0];
    assign front_ext   = EXT_W'(front_head);
    assign back_ext    = EXT_W'(back_head);

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_popped = '0;
        op_front = CELL_HOLD;
        op_back  = CELL_HOLD;
        if (accept) begin
            case (cmd_in)
                CMD_PUSH_FRONT: begin
                    if (full) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        op_front = CELL_SHIFT_IN;
                        op_back  = CELL_WRITE;
                        n_count  = r_count + 1'b1;
                    end
                end
                CMD_PUSH_BACK: begin
                    if (full) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        op_front = CELL_WRITE;
                        op_back  = CELL_SHIFT_IN;
                        n_count  = r_count + 1'b1;
                    end
                end
                CMD_POP_FRONT: begin
                    if (empty) begin
                        n_status = ST_UNDERFLOW;
                    end else begin
                        n_popped = front_ext[VALUE_W-1:0];
                        op_front = CELL_SHIFT_OUT;
                        n_count  = r_count - 1'b1;
                    end
                end
                CMD_POP_BACK: begin
                    if (empty) begin
                        n_status = ST_UNDERFLOW;
                    end else begin
                        n_popped = back_ext[VALUE_W-1:0];
                        op_back  = CELL_SHIFT_OUT;
                        n_count  = r_count - 1'b1;
                    end
                end
                CMD_CLEAR: n_count = '0;
                default:   n_count = r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_popped <= n_popped;
        end
    end

    dq_chain #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CW         (CW)
    ) u_front_row (
        .i_clk   (i_clk),
        .i_op    (op_front),
        .i_count (r_count),
        .i_value (value),
        .o_head  (front_head)
    );

    dq_chain #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CW         (CW)
    ) u_back_row (
        .i_clk   (i_clk),
        .i_op    (op_back),
        .i_count (r_count),
        .i_value (value),
        .o_head  (back_head)
    );

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_status;
    assign o_res.popped_value = r_popped;
    assign o_res.front_value  = empty ? '0 : front_ext[VALUE_W-1:0];
    assign o_res.back_value   = empty ? '0 : back_ext[VALUE_W-1:0];
    assign o_res.occupancy    = OCC_W'(r_count);
    assign o_res.is_empty     = empty;

endmodule

// ===== bench/tb.sv =====
module tb;
    import dq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEQUE_DEPTH = 16;
    localparam int IDX_W = $clog2(DEQUE_DEPTH);
    localparam int MAX_REPORTS = 40;
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct packed {
        t_status             status;
        logic [VALUE_W-1:0]  popped_value;
        logic [VALUE_W-1:0]  front_value;
        logic [VALUE_W-1:0]  back_value;
        logic [OCC_W-1:0]    occupancy;
        logic                is_empty;
    } t_deque_result;

    logic i_clk;
    logic i_rst_n;

    dq_cmd_if cmd_bus ();
    dq_res_if res_bus ();

    double_ended_queue #(
        .DEPTH      (DEQUE_DEPTH),
        .DATA_WIDTH (VALUE_W)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    logic [VALUE_W-1:0] deque_store [DEQUE_DEPTH];
    logic [IDX_W-1:0]   deque_head = '0;
    logic [OCC_W-1:0]   deque_count = '0;
    t_deque_result      pending_results [$];
    int                 error_count = 0;
    bit                 idle_on = 1'b1;
    int                 hold_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("tb: done, errors");
        $finish;
    end

    // The receiver stalls at random when idle_on, or for a counted hold-off when asked.
    initial begin
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                res_bus.ready <= 1'b0;
                hold_cycles--;
            end else if (idle_on && $urandom_range(99) < 30) begin
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                   logic [VALUE_W-1:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("tb: %0t %s: got %h, want %h", $time, what, got, want);
        end
    endtask

    task automatic check_field(string what, logic [VALUE_W-1:0] got,
                               logic [VALUE_W-1:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    task automatic predict_deque_result(logic [CMD_W-1:0] code, logic [VALUE_W-1:0] value);
        t_deque_result    r;
        logic [IDX_W-1:0] idx;
        r = '0;
        r.status = ST_OK;
        case (code)
            CMD_PUSH_FRONT: begin
                if (deque_count == DEQUE_DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    deque_head = deque_head - 1'b1;
                    deque_store[deque_head] = value;
                    deque_count++;
                end
            end
            CMD_PUSH_BACK: begin
                if (deque_count == DEQUE_DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    idx = deque_head + deque_count[IDX_W-1:0];
                    deque_store[idx] = value;
                    deque_count++;
                end
            end
            CMD_POP_FRONT: begin
                if (deque_count == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    r.popped_value = deque_store[deque_head];
                    deque_head = deque_head + 1'b1;
                    deque_count--;
                end
            end
            CMD_POP_BACK: begin
                if (deque_count == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    idx = deque_head + deque_count[IDX_W-1:0] - 1'b1;
                    r.popped_value = deque_store[idx];
                    deque_count--;
                end
            end
            CMD_CLEAR: begin
                deque_head = '0;
                deque_count = '0;
            end
            default: begin
            end
        endcase
        if (deque_count != 0) begin
            idx = deque_head + deque_count[IDX_W-1:0] - 1'b1;
            r.front_value = deque_store[deque_head];
            r.back_value = deque_store[idx];
        end
        r.occupancy = deque_count;
        r.is_empty = (deque_count == 0);
        pending_results.insert(pending_results.size(), r);
    endtask

    always @(posedge i_clk) begin
        t_deque_result want;
        if (i_rst_n && cmd_bus.valid && cmd_bus.ready) begin
            predict_deque_result(cmd_bus.cmd, cmd_bus.push_value);
        end
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with none pending", res_bus.front_value, '0);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                check_field("status", res_bus.status, want.status);
                check_field("popped_value", res_bus.popped_value, want.popped_value);
                check_field("front_value", res_bus.front_value, want.front_value);
                check_field("back_value", res_bus.back_value, want.back_value);
                check_field("occupancy", res_bus.occupancy, want.occupancy);
                check_field("is_empty", res_bus.is_empty, want.is_empty);
            end
        end
    end

    task automatic send_command(logic [CMD_W-1:0] code, logic [VALUE_W-1:0] value);
        if (idle_on && $urandom_range(99) < 30) begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.cmd <= code;
        cmd_bus.push_value <= value;
        do @(posedge i_clk); while (!cmd_bus.ready);
    endtask

    task automatic wait_for_drain();
        cmd_bus.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending_results.size() == 0);
        @(posedge i_clk);
    endtask

    function automatic logic [CMD_W-1:0] pick_command(int push_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (r < push_pct) return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        if (r < 94) return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
        if (r < 96) return CMD_CLEAR;
        if (r < 99) return CMD_QUERY;
        return $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(7) != 0) return $urandom;
        case ($urandom_range(4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0001;
            default: return '0;
        endcase
    endfunction

    task automatic test_empty_queue();
        send_command(CMD_QUERY, 32'h1234_5678);
        send_command(CMD_POP_FRONT, '0);
        send_command(CMD_POP_BACK, 32'hFFFF_FFFF);
        send_command(CMD_SPARE_LO, 32'h8000_0000);
        send_command(CMD_SPARE_HI, 32'h7FFF_FFFF);
    endtask

    task automatic test_fill_and_overflow();
        logic [VALUE_W-1:0] pattern [4];
        pattern = '{32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000, 32'hFFFF_FFFF};
        send_command(CMD_PUSH_FRONT, 32'h8000_0000);
        send_command(CMD_PUSH_BACK, 32'h7FFF_FFFF);
        for (int i = 0; i < DEQUE_DEPTH - 2; i++) begin
            send_command(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pattern[i % 4]);
        end
        send_command(CMD_PUSH_FRONT, 32'h0BAD_0BAD);
        send_command(CMD_PUSH_BACK, 32'hDEAD_BEEF);
    endtask

    task automatic test_pop_and_clear();
        send_command(CMD_POP_FRONT, '0);
        send_command(CMD_POP_BACK, '0);
        send_command(CMD_CLEAR, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_traffic(int count, int push_pct);
        for (int i = 0; i < count; i++) begin
            send_command(pick_command(push_pct), pick_value());
        end
    endtask

    task automatic test_back_pressure();
        idle_on = 1'b0;
        hold_cycles = 80;
        test_random_traffic(40, 60);
        wait_for_drain();
        idle_on = 1'b1;
    endtask

    task automatic test_no_idle_stretch();
        idle_on = 1'b0;
        test_random_traffic(200, 50);
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        cmd_bus.valid <= 1'b0;
        cmd_bus.cmd <= CMD_QUERY;
        cmd_bus.push_value <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_fill_and_overflow();
        test_pop_and_clear();
        test_random_traffic(300, 55);
        test_back_pressure();
        test_no_idle_stretch();
        test_random_traffic(300, 38);

        wait_for_drain();
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
